[rtl/hp2v_pkg.sv]
// Types, constants and helper functions for the haptic pose to velocity filter.
package hp2v_pkg;

	// Default depth of the axis zero history.
	localparam int unsigned MAX_HISTORY_DEF = 8;

	// Register reset values.
	localparam logic [30:0] DEADBAND_RST = 31'd655;
	localparam logic [30:0] GAIN_RST     = 31'd16384;
	localparam logic [3:0]  HIST_LEN_RST = 4'd6;

	// Identity quaternion w term in Q2.14.
	localparam logic signed [15:0] QUAT_ONE = 16'sd16384;

	// 2e6 / 4096 equals 15625 / 32, so the angular term is |t| * 15625 over 32 * dt.
	localparam logic signed [31:0] ANG_SCALE = 32'sd15625;

	// Width of the restoring division dividend, one quotient bit per cycle.
	localparam int unsigned DIV_BITS = 47;

	// Sign pattern of the twelve quaternion product terms, bit j set when term j of
	// an axis is subtracted.
	localparam logic [3:0] TERM_NEG [3] = '{4'b0110, 4'b1100, 4'b1010};

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_DEADBAND = 2'd0,
		REG_GAIN     = 2'd1,
		REG_HIST_LEN = 2'd2,
		REG_NONE     = 2'd3
	} cfg_reg_t;

	// Input opcodes.
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_BUTTON = 1'b1
	} opcode_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_QMUL,
		ST_AMUL,
		ST_DINIT,
		ST_DIV,
		ST_DDONE,
		ST_FILT,
		ST_HIST,
		ST_PUSH,
		ST_SMUL,
		ST_SRND,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic               opcode;
		logic               button_pressed;
		logic [31:0]        stamp_us;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_lin_x;
		logic signed [31:0] out_lin_y;
		logic signed [31:0] out_lin_z;
		logic signed [31:0] out_ang_x;
		logic signed [31:0] out_ang_y;
		logic signed [31:0] out_ang_z;
		logic [31:0]        out_stamp_us;
	} cmd_t;

	// Saturate a signed magnitude to a 32-bit signed value.
	function automatic logic signed [31:0] sat_mag(input logic neg, input logic [47:0] mag);
		logic [31:0] low;
		low = mag[31:0];
		if (!neg) begin
			if (mag > 48'h0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
			return low;
		end
		if (mag >= 48'h0000_8000_0000) return 32'sh8000_0000;
		return 32'(-low);
	endfunction

endpackage

[rtl/haptic_pose_to_velocity_filter.sv]
// Haptic pose to velocity filter: sequencer around one shared multiplier and a serial divider.
//
// Button requests and samples taken while movement is disabled finish without leaving the idle state.
// An enabled sample keeps the sequencer busy: twelve quaternion products through the
// shared multiplier, then for each angular axis a scaling product and a 47-bit restoring
// division (one quotient bit a cycle), one history entry read a cycle for each entry
// checked, and six gain products with rounding. A stalled output register holds the
// sequencer in its output step. A new request is taken as soon as the sequencer is idle,
// even while the previous command still waits in the output register.
// Angular axes are zero when two samples carry the same timestamp.
module haptic_pose_to_velocity_filter #(
	parameter int unsigned MAX_HISTORY = hp2v_pkg::MAX_HISTORY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  hp2v_pkg::req_t   req_data,
	output logic             cmd_valid,
	input  logic             cmd_stall,
	output hp2v_pkg::cmd_t   cmd_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [30:0]      cfg_data
);

	localparam int unsigned HW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
	localparam int unsigned FW = $clog2(MAX_HISTORY + 1);
	localparam int unsigned CW = (FW > 4) ? FW : 4;
	localparam int unsigned SW = CW + 2;
	localparam int unsigned DB = hp2v_pkg::DIV_BITS;

	hp2v_pkg::state_t state_q, state_d;

	// Configuration and control state.
	logic [30:0]        deadband_q, gain_q;
	logic [3:0]         hist_len_q;
	logic               enabled_q;
	logic [31:0]        prev_stamp_q;
	logic signed [15:0] prev_quat_q [4];
	logic [HW-1:0]      head_q;
	logic [FW-1:0]      fill_q;
	logic [5:0]         cnt_q;
	logic [2:0]         ax_q;
	logic [CW-1:0]      hk_q, n_q;
	logic               rd_vld_q;
	logic               cmd_valid_q;

	// Working payload.
	logic signed [15:0] q1_q [4];
	logic signed [15:0] q2_q [4];
	logic [31:0]        stamp_q, dt_q;
	logic signed [33:0] t_q [3];
	logic signed [31:0] v_q [6];
	logic signed [65:0] prod_q;
	logic [36:0]        rem_q;
	logic [DB-1:0]      quo_q;
	logic               neg_q;
	logic [5:0]         zmask_q, kill_q, rd_q;
	hp2v_pkg::cmd_t     cmd_q;
	logic [5:0]         mem [MAX_HISTORY];

	// Handshake terms.
	logic accept, is_sample, out_free;
	assign accept    = req_valid && !req_stall;
	assign is_sample = hp2v_pkg::opcode_t'(req_data.opcode) == hp2v_pkg::OP_SAMPLE;
	assign req_stall = state_q != hp2v_pkg::ST_IDLE;
	assign out_free  = !cmd_valid_q || !cmd_stall;
	assign cmd_valid = cmd_valid_q;
	assign cmd_data  = cmd_q;

	// Shared multiplier operand selection.
	logic signed [33:0] mul_a;
	logic signed [31:0] mul_b;
	logic [1:0]         tj, tc, tax;
	always_comb begin
		tj    = cnt_q[1:0];
		tax   = cnt_q[3:2];
		tc    = tj ^ (tax + 2'd1);
		mul_a = 34'(q1_q[tj]);
		mul_b = 32'(q2_q[tc]);
		unique case (state_q)
			hp2v_pkg::ST_AMUL: begin
				mul_a = t_q[ax_q[1:0]];
				mul_b = hp2v_pkg::ANG_SCALE;
			end
			hp2v_pkg::ST_SMUL: begin
				mul_a = 34'(v_q[ax_q]);
				mul_b = $signed({1'b0, gain_q});
			end
			default: begin
			end
		endcase
	end

	// Product magnitude, division step and rounding helpers.
	logic [65:0]   pmag;
	logic [37:0]   dtrial;
	logic [36:0]   dvsr;
	logic          dbit;
	logic [47:0]   smag;
	logic [3:0]    kterm;
	logic [1:0]    kax, kj;
	logic signed [33:0] pterm;
	always_comb begin
		pmag   = prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
		dvsr   = {dt_q, 5'd0};
		dtrial = {rem_q, quo_q[DB-1]};
		dbit   = dtrial >= {1'b0, dvsr};
		smag   = 48'((pmag + 66'd32768) >> 16);
		kterm  = cnt_q[3:0] - 4'd1;
		kax    = kterm[3:2];
		kj     = kterm[1:0];
		pterm  = 34'(prod_q);
	end

	// History read address and count of entries to check.
	logic [SW-1:0] asum;
	logic [HW-1:0] raddr;
	logic [CW-1:0] nsel;
	always_comb begin
		asum  = SW'(head_q) + SW'(MAX_HISTORY - 1) - SW'(hk_q);
		raddr = (asum >= SW'(MAX_HISTORY)) ? HW'(asum - SW'(MAX_HISTORY)) : HW'(asum);
		nsel  = (CW'(hist_len_q) < CW'(fill_q)) ? CW'(hist_len_q) : CW'(fill_q);
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hp2v_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hp2v_pkg::ST_IDLE: begin
				if (accept && is_sample && enabled_q) state_d = hp2v_pkg::ST_QMUL;
			end
			hp2v_pkg::ST_QMUL: begin
				if (cnt_q == 6'd12) state_d = hp2v_pkg::ST_AMUL;
			end
			hp2v_pkg::ST_AMUL:  state_d = hp2v_pkg::ST_DINIT;
			hp2v_pkg::ST_DINIT: state_d = hp2v_pkg::ST_DIV;
			hp2v_pkg::ST_DIV: begin
				if (cnt_q == 6'(DB - 1)) state_d = hp2v_pkg::ST_DDONE;
			end
			hp2v_pkg::ST_DDONE: begin
				state_d = (ax_q == 3'd2) ? hp2v_pkg::ST_FILT : hp2v_pkg::ST_AMUL;
			end
			hp2v_pkg::ST_FILT: state_d = hp2v_pkg::ST_HIST;
			hp2v_pkg::ST_HIST: begin
				if (hk_q == n_q) state_d = hp2v_pkg::ST_PUSH;
			end
			hp2v_pkg::ST_PUSH: state_d = hp2v_pkg::ST_SMUL;
			hp2v_pkg::ST_SMUL: state_d = hp2v_pkg::ST_SRND;
			hp2v_pkg::ST_SRND: begin
				state_d = (ax_q == 3'd5) ? hp2v_pkg::ST_OUT : hp2v_pkg::ST_SMUL;
			end
			hp2v_pkg::ST_OUT: begin
				if (out_free) state_d = hp2v_pkg::ST_IDLE;
			end
			default: state_d = hp2v_pkg::ST_IDLE;
		endcase
	end

	// Control registers: configuration, enable, previous sample, history pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q     <= hp2v_pkg::DEADBAND_RST;
			gain_q         <= hp2v_pkg::GAIN_RST;
			hist_len_q     <= hp2v_pkg::HIST_LEN_RST;
			enabled_q      <= 1'b0;
			prev_stamp_q   <= '0;
			prev_quat_q[0] <= hp2v_pkg::QUAT_ONE;
			prev_quat_q[1] <= '0;
			prev_quat_q[2] <= '0;
			prev_quat_q[3] <= '0;
			head_q         <= '0;
			fill_q         <= '0;
			cnt_q          <= '0;
			ax_q           <= '0;
			hk_q           <= '0;
			rd_vld_q       <= 1'b0;
			cmd_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (hp2v_pkg::cfg_reg_t'(cfg_idx))
					hp2v_pkg::REG_DEADBAND: deadband_q <= cfg_data;
					hp2v_pkg::REG_GAIN:     gain_q     <= cfg_data;
					hp2v_pkg::REG_HIST_LEN: hist_len_q <= cfg_data[3:0];
					hp2v_pkg::REG_NONE:     ;
				endcase
			end
			// A finished command is loaded as the previous one leaves.
			if (state_q == hp2v_pkg::ST_OUT && out_free) begin
				cmd_valid_q <= 1'b1;
			end else if (cmd_valid_q && !cmd_stall) begin
				cmd_valid_q <= 1'b0;
			end
			unique case (state_q)
				hp2v_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (!is_sample) begin
							enabled_q <= req_data.button_pressed;
						end else begin
							prev_stamp_q   <= req_data.stamp_us;
							prev_quat_q[0] <= req_data.quat_w;
							prev_quat_q[1] <= req_data.quat_x;
							prev_quat_q[2] <= req_data.quat_y;
							prev_quat_q[3] <= req_data.quat_z;
						end
					end
				end
				hp2v_pkg::ST_QMUL: begin
					cnt_q <= cnt_q + 6'd1;
					ax_q  <= '0;
				end
				hp2v_pkg::ST_DINIT: cnt_q <= '0;
				hp2v_pkg::ST_DIV:   cnt_q <= cnt_q + 6'd1;
				hp2v_pkg::ST_DDONE: begin
					ax_q <= (ax_q == 3'd2) ? 3'd0 : ax_q + 3'd1;
				end
				hp2v_pkg::ST_FILT: begin
					hk_q     <= '0;
					rd_vld_q <= 1'b0;
				end
				hp2v_pkg::ST_HIST: begin
					rd_vld_q <= hk_q != n_q;
					if (hk_q != n_q) hk_q <= hk_q + CW'(1);
				end
				hp2v_pkg::ST_PUSH: begin
					head_q <= (head_q == HW'(MAX_HISTORY - 1)) ? '0 : head_q + HW'(1);
					if (fill_q != FW'(MAX_HISTORY)) fill_q <= fill_q + FW'(1);
					ax_q   <= '0;
				end
				hp2v_pkg::ST_SRND: begin
					if (ax_q != 3'd5) ax_q <= ax_q + 3'd1;
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers and the history memory.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		rd_q   <= mem[raddr];
		unique case (state_q)
			hp2v_pkg::ST_IDLE: begin
				q1_q    <= prev_quat_q;
				q2_q[0] <= req_data.quat_w;
				q2_q[1] <= req_data.quat_x;
				q2_q[2] <= req_data.quat_y;
				q2_q[3] <= req_data.quat_z;
				stamp_q <= req_data.stamp_us;
				dt_q    <= req_data.stamp_us - prev_stamp_q;
				v_q[0]  <= req_data.vel_x;
				v_q[1]  <= req_data.vel_y;
				v_q[2]  <= req_data.vel_z;
			end
			hp2v_pkg::ST_QMUL: begin
				// Accumulate the product issued in the previous cycle.
				if (cnt_q == 6'd0) begin
					t_q[0] <= '0;
					t_q[1] <= '0;
					t_q[2] <= '0;
				end else if (hp2v_pkg::TERM_NEG[kax][kj]) begin
					t_q[kax] <= t_q[kax] - pterm;
				end else begin
					t_q[kax] <= t_q[kax] + pterm;
				end
			end
			hp2v_pkg::ST_DINIT: begin
				// Rounded quotient: (|t| * 15625 + 16 dt) / (32 dt).
				rem_q <= '0;
				quo_q <= DB'(pmag) + DB'({dt_q, 4'd0});
				neg_q <= prod_q[65];
			end
			hp2v_pkg::ST_DIV: begin
				rem_q <= dbit ? 37'(dtrial - {1'b0, dvsr}) : dtrial[36:0];
				quo_q <= {quo_q[DB-2:0], dbit};
			end
			hp2v_pkg::ST_DDONE: begin
				v_q[3 + ax_q] <= (dt_q == '0) ? 32'sd0 :
					hp2v_pkg::sat_mag(neg_q, 48'(quo_q));
			end
			hp2v_pkg::ST_FILT: begin
				// Deadband each axis and note which axes ended up zero.
				kill_q <= '0;
				n_q    <= nsel;
				for (int a = 0; a < 6; a++) begin
					if ((v_q[a][31] ? 33'(-34'(v_q[a])) : 33'(v_q[a])) < {2'b00, deadband_q}
							|| v_q[a] == '0) begin
						v_q[a]     <= '0;
						zmask_q[a] <= 1'b1;
					end else begin
						zmask_q[a] <= 1'b0;
					end
				end
			end
			hp2v_pkg::ST_HIST: begin
				if (rd_vld_q) kill_q <= kill_q | rd_q;
			end
			hp2v_pkg::ST_PUSH: begin
				mem[head_q] <= zmask_q;
				for (int a = 0; a < 6; a++) begin
					if (kill_q[a]) v_q[a] <= '0;
				end
			end
			hp2v_pkg::ST_SRND: begin
				v_q[ax_q] <= hp2v_pkg::sat_mag(prod_q[65], smag);
			end
			hp2v_pkg::ST_OUT: begin
				if (out_free) begin
					cmd_q.out_lin_x    <= (v_q[1] == 32'sh8000_0000) ? 32'sh7FFF_FFFF :
						32'(-v_q[1]);
					cmd_q.out_lin_y    <= v_q[0];
					cmd_q.out_lin_z    <= v_q[2];
					cmd_q.out_ang_x    <= v_q[3];
					cmd_q.out_ang_y    <= v_q[4];
					cmd_q.out_ang_z    <= v_q[5];
					cmd_q.out_stamp_us <= stamp_q;
				end
			end
			default: begin
			end
		endcase
	end

	// A command appears only when the sequencer finishes an enabled sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd_valid_q) |-> $past(state_q == hp2v_pkg::ST_OUT))
		else $error("command raised outside the output step");

	// The fill count never passes the history depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_HISTORY))
		else $error("history fill count overflow");

	// The divider step count never passes its bit count.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hp2v_pkg::ST_DIV |-> cnt_q < 6'(DB))
		else $error("divider step count overrun");

	// The history scan never reads more entries than have been written.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hp2v_pkg::ST_HIST |-> hk_q <= CW'(fill_q))
		else $error("history scan beyond filled entries");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the haptic pose to velocity filter.
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned HIST_DEPTH = hp2v_pkg::MAX_HISTORY_DEF;
	localparam int unsigned SETTLE_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 1000000;

	logic            clk;
	logic            arst_n;
	logic            req_valid;
	logic            req_stall;
	hp2v_pkg::req_t  req_data;
	logic            cmd_valid;
	logic            cmd_stall;
	hp2v_pkg::cmd_t  cmd_data;
	logic            cfg_we;
	logic [1:0]      cfg_idx;
	logic [30:0]     cfg_data;

	// Shadow copy of the block's state and registers.
	logic [30:0]  sh_deadband;
	logic [30:0]  sh_gain;
	logic [3:0]   sh_hist_len;
	bit           sh_enabled;
	logic [31:0]  sh_stamp;
	longint       sh_quat [4];
	logic [5:0]   sh_zero_hist [HIST_DEPTH];
	int unsigned  sh_fill;
	int unsigned  sh_head;

	hp2v_pkg::cmd_t cmd_queue [$];
	int unsigned  error_count;
	int unsigned  cmd_count;
	int unsigned  req_count;
	int unsigned  stall_left;
	bit           stall_drawn;
	bit           calm;
	longint       cycles;
	logic [31:0]  stamp_cursor;

	haptic_pose_to_velocity_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	// Clock with a 20 ns period.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d commands pending", cycles,
				cmd_queue.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Saturate to 32 bits signed.
	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// Division rounded to nearest, ties away from zero; den is positive.
	function automatic longint div_nearest(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	// Turn one request into the command it causes, if any, and advance the shadow state.
	task automatic filter_request(input hp2v_pkg::req_t r, output bit hit,
			output hp2v_pkg::cmd_t c);
		longint t [3];
		longint v [6];
		longint qw;
		longint qx;
		longint qy;
		longint qz;
		longint mag;
		logic [31:0] dt;
		logic [5:0] zmask;
		logic [5:0] kill;
		int unsigned n;
		hit = 1'b0;
		c = '0;
		if (r.opcode == hp2v_pkg::OP_BUTTON) begin
			sh_enabled = r.button_pressed;
			return;
		end
		qw = longint'(r.quat_w);
		qx = longint'(r.quat_x);
		qy = longint'(r.quat_y);
		qz = longint'(r.quat_z);
		if (sh_enabled) begin
			dt = r.stamp_us - sh_stamp;
			t[0] = sh_quat[0] * qx - sh_quat[1] * qw - sh_quat[2] * qz + sh_quat[3] * qy;
			t[1] = sh_quat[0] * qy + sh_quat[1] * qz - sh_quat[2] * qw - sh_quat[3] * qx;
			t[2] = sh_quat[0] * qz - sh_quat[1] * qy + sh_quat[2] * qx - sh_quat[3] * qw;
			v[0] = longint'(r.vel_x);
			v[1] = longint'(r.vel_y);
			v[2] = longint'(r.vel_z);
			for (int a = 0; a < 3; a++) begin
				if (dt == 0) v[3 + a] = 0;
				else v[3 + a] = clamp32(div_nearest(t[a] * 2000000, longint'(dt) * 4096));
			end
			// Deadband, then the zero mask of this sample.
			zmask = '0;
			for (int a = 0; a < 6; a++) begin
				mag = (v[a] < 0) ? -v[a] : v[a];
				if (mag < longint'(sh_deadband)) v[a] = 0;
				if (v[a] == 0) zmask[a] = 1'b1;
			end
			// Any recent zero on an axis keeps it at zero.
			n = 32'(sh_hist_len);
			if (n > HIST_DEPTH) n = HIST_DEPTH;
			if (n > sh_fill) n = sh_fill;
			kill = '0;
			for (int unsigned k = 1; k <= n; k++)
				kill |= sh_zero_hist[(sh_head + HIST_DEPTH - k) % HIST_DEPTH];
			sh_zero_hist[sh_head] = zmask;
			sh_head = (sh_head + 1) % HIST_DEPTH;
			if (sh_fill < HIST_DEPTH) sh_fill++;
			for (int a = 0; a < 6; a++) begin
				if (kill[a]) v[a] = 0;
				v[a] = clamp32(div_nearest(v[a] * longint'(sh_gain), 65536));
			end
			c.out_lin_x = clamp32(-v[1]);
			c.out_lin_y = v[0][31:0];
			c.out_lin_z = v[2][31:0];
			c.out_ang_x = v[3][31:0];
			c.out_ang_y = v[4][31:0];
			c.out_ang_z = v[5][31:0];
			c.out_stamp_us = r.stamp_us;
			hit = 1'b1;
		end
		sh_stamp = r.stamp_us;
		sh_quat[0] = qw;
		sh_quat[1] = qx;
		sh_quat[2] = qy;
		sh_quat[3] = qz;
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("Mismatch on %s: got %h, expected %h at cycle %0d", what, got, want, cycles);
		error_count++;
	endtask

	// Send one request after a random gap and predict its command on acceptance.
	task automatic send_request(input hp2v_pkg::req_t r);
		int unsigned gap;
		bit hit;
		hp2v_pkg::cmd_t c;
		gap = calm ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (req_stall);
		filter_request(r, hit, c);
		req_count++;
		if (hit) cmd_queue.insert(cmd_queue.size(), c);
	endtask

	// Drop valid and wait until the block has drained every command.
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		wait (cmd_queue.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input hp2v_pkg::cfg_reg_t idx, input logic [30:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			hp2v_pkg::REG_DEADBAND: sh_deadband = value;
			hp2v_pkg::REG_GAIN:     sh_gain = value;
			hp2v_pkg::REG_HIST_LEN: sh_hist_len = value[3:0];
			default: ;
		endcase
	endtask

	task automatic set_filter(input logic [30:0] db, input logic [30:0] g, input logic [3:0] hl);
		drain();
		write_reg(hp2v_pkg::REG_DEADBAND, db);
		write_reg(hp2v_pkg::REG_GAIN, g);
		write_reg(hp2v_pkg::REG_HIST_LEN, hl);
	endtask

	function automatic hp2v_pkg::req_t button_req(input bit pressed);
		hp2v_pkg::req_t r;
		logic [223:0] noise;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = noise[$bits(hp2v_pkg::req_t)-1:0];
		r.opcode = hp2v_pkg::OP_BUTTON;
		r.button_pressed = pressed;
		return r;
	endfunction

	function automatic logic signed [31:0] pick_vel();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 32'sh8000_0000;
			2: return 32'sh7FFF_FFFF;
			3, 4: return $signed($urandom_range(0, 2000)) - 1000;
			5: return $signed($urandom_range(0, 400000)) - 200000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [15:0] pick_quat();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return $signed(16'($urandom_range(0, 600))) - 16'sd300;
			default: return 16'($urandom);
		endcase
	endfunction

	// A sample with a plausible time step most of the time.
	function automatic hp2v_pkg::req_t sample_req();
		hp2v_pkg::req_t r;
		logic [223:0] noise;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = noise[$bits(hp2v_pkg::req_t)-1:0];
		r.opcode = hp2v_pkg::OP_SAMPLE;
		case ($urandom_range(0, 9))
			0: ;
			1: stamp_cursor = $urandom;
			2: stamp_cursor = stamp_cursor + 32'hFFFF_0000 + $urandom_range(0, 65535);
			default: stamp_cursor = stamp_cursor + $urandom_range(1, 2000);
		endcase
		r.stamp_us = stamp_cursor;
		r.vel_x = pick_vel();
		r.vel_y = pick_vel();
		r.vel_z = pick_vel();
		r.quat_w = pick_quat();
		r.quat_x = pick_quat();
		r.quat_y = pick_quat();
		r.quat_z = pick_quat();
		return r;
	endfunction

	// Random mix of samples and button requests, mostly with movement enabled.
	task automatic run_random(input int unsigned count);
		int unsigned roll;
		for (int unsigned i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 3) send_request(button_req(1'b0));
			else if (roll < 10) send_request(button_req(1'b1));
			else send_request(sample_req());
		end
	endtask

	// Extremes of the fields and the special cases, under reset settings.
	task automatic test_directed();
		hp2v_pkg::req_t r;
		r = sample_req();
		send_request(r);
		send_request(button_req(1'b1));
		r = sample_req();
		r.stamp_us = stamp_cursor;
		send_request(r);
		send_request(r);
		r.vel_x = 32'sh8000_0000;
		r.vel_y = 32'sh8000_0000;
		r.vel_z = 32'sh7FFF_FFFF;
		r.quat_w = 16'sh8000;
		r.quat_x = 16'sh7FFF;
		r.quat_y = 16'sh8000;
		r.quat_z = 16'sh7FFF;
		r.stamp_us = r.stamp_us + 32'd1;
		send_request(r);
		r.quat_w = 16'sh7FFF;
		r.quat_x = 16'sh8000;
		r.quat_y = 16'sh7FFF;
		r.quat_z = 16'sh8000;
		r.stamp_us = r.stamp_us + 32'hFFFF_FFFF;
		send_request(r);
		for (int i = 0; i < 10; i++) send_request(sample_req());
		send_request(button_req(1'b0));
		send_request(sample_req());
		send_request(button_req(1'b1));
		send_request(sample_req());
	endtask

	// Negation of the most negative scaled value at unity gain.
	task automatic test_rotation_overflow();
		hp2v_pkg::req_t r;
		set_filter(31'd0, 31'd65536, 4'd0);
		r = sample_req();
		r.vel_y = 32'sh8000_0000;
		r.vel_x = 32'sh8000_0000;
		send_request(r);
		send_request(r);
	endtask

	// Random traffic under a sweep of filter settings, extremes among them.
	task automatic test_settings_sweep();
		set_filter(31'd655, 31'd16384, 4'd6);
		run_random(120);
		set_filter(31'd0, 31'h7FFF_FFFF, 4'd1);
		run_random(80);
		set_filter(31'h7FFF_FFFF, 31'd65536, 4'd8);
		run_random(40);
		set_filter(31'd700, 31'd0, 4'd15);
		run_random(40);
		set_filter(31'd2000, 31'd131072, 4'd0);
		write_reg(hp2v_pkg::REG_NONE, 31'h5555_5555);
		calm = 1'b1;
		run_random(80);
		calm = 1'b0;
		set_filter(31'd1, 31'd40000, 4'd3);
		run_random(120);
		set_filter(31'd655, 31'd65536, 4'd9);
		run_random(120);
	endtask

	// The sender holds off until every command has come, several times over.
	task automatic test_hold_off();
		set_filter(31'd300, 31'd70000, 4'd4);
		for (int i = 0; i < 5; i++) begin
			run_random(25);
			@(negedge clk);
			req_valid <= 1'b0;
			wait (cmd_queue.size() == 0);
		end
	endtask

	// Receiver stall: a random number of stalled cycles once each command is offered.
	always @(negedge clk) begin
		if (cmd_valid && !stall_drawn) begin
			stall_left = calm ? 0 : $urandom_range(0, 3);
			stall_drawn = 1'b1;
		end
		if (stall_left > 0) begin
			cmd_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			cmd_stall <= 1'b0;
		end
	end

	// Compare each accepted command with the oldest prediction.
	always @(posedge clk) begin
		hp2v_pkg::cmd_t want;
		if (arst_n && cmd_valid && !cmd_stall) begin
			stall_drawn = 1'b0;
			if (cmd_queue.size() == 0) begin
				report("unexpected command stamp", cmd_data.out_stamp_us, '0);
			end else begin
				want = cmd_queue.pop_front();
				cmd_count++;
				if (cmd_data.out_lin_x !== want.out_lin_x)
					report("out_lin_x", cmd_data.out_lin_x, want.out_lin_x);
				if (cmd_data.out_lin_y !== want.out_lin_y)
					report("out_lin_y", cmd_data.out_lin_y, want.out_lin_y);
				if (cmd_data.out_lin_z !== want.out_lin_z)
					report("out_lin_z", cmd_data.out_lin_z, want.out_lin_z);
				if (cmd_data.out_ang_x !== want.out_ang_x)
					report("out_ang_x", cmd_data.out_ang_x, want.out_ang_x);
				if (cmd_data.out_ang_y !== want.out_ang_y)
					report("out_ang_y", cmd_data.out_ang_y, want.out_ang_y);
				if (cmd_data.out_ang_z !== want.out_ang_z)
					report("out_ang_z", cmd_data.out_ang_z, want.out_ang_z);
				if (cmd_data.out_stamp_us !== want.out_stamp_us)
					report("out_stamp_us", cmd_data.out_stamp_us, want.out_stamp_us);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		cmd_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = hp2v_pkg::REG_DEADBAND;
		cfg_data = '0;
		cycles = 0;
		error_count = 0;
		cmd_count = 0;
		req_count = 0;
		stall_left = 0;
		stall_drawn = 1'b0;
		calm = 1'b0;
		stamp_cursor = 32'd1000;
		sh_deadband = hp2v_pkg::DEADBAND_RST;
		sh_gain = hp2v_pkg::GAIN_RST;
		sh_hist_len = hp2v_pkg::HIST_LEN_RST;
		sh_enabled = 1'b0;
		sh_stamp = '0;
		sh_quat[0] = 16384;
		sh_quat[1] = 0;
		sh_quat[2] = 0;
		sh_quat[3] = 0;
		sh_fill = 0;
		sh_head = 0;
		foreach (sh_zero_hist[i]) sh_zero_hist[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_rotation_overflow();
		test_settings_sweep();
		test_hold_off();
		drain();

		$display("Sent %0d requests and checked %0d commands across ten filter settings,",
			req_count, cmd_count);
		$display("with history lengths from 0 to 15, zero and full-scale deadband and gain.");
		if (error_count == 0 && cmd_queue.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d commands never arrived", error_count,
				cmd_queue.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
